// ===== sv/sstc_pkg.sv =====
package sstc_pkg;

    // Item and register widths.
    localparam int ANGLE_BITS     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int BLEND_SHIFT    = 16;
    localparam int STIFF_W        = 12;
    localparam int EQ_W           = 11;
    localparam int DAMP_W         = 10;
    localparam int ALPHA_W        = 16;
    localparam int LIMIT_W        = 15;
    localparam int TORQUE_W       = 16;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    // Derived datapath widths.
    localparam int GAIN_W       = STIFF_W + BLEND_SHIFT;
    localparam int DELTA_W      = ANGLE_BITS + 1;
    localparam int ERR_W        = ((ANGLE_BITS > EQ_W) ? ANGLE_BITS : EQ_W) + 1;
    localparam int MUL_A_W      = GAIN_W + 1;
    localparam int MUL_B_W      = (ERR_W > ALPHA_W + 1) ? ERR_W : ALPHA_W + 1;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
    localparam int SPRING_SHIFT = BLEND_SHIFT + GAIN_FRAC_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // One step per cycle, STEP_OUT may hold; later steps retire the prior product.
    typedef enum logic [2:0] {
        STEP_BLEND_R,
        STEP_BLEND_L,
        STEP_SPRING_R,
        STEP_SPRING_L,
        STEP_DAMP_R,
        STEP_DAMP_L,
        STEP_SUM_L,
        STEP_OUT
    } step_t;

    typedef enum logic [2:0] {
        REG_STANCE_STIFFNESS,
        REG_EQUILIBRIUM_ANGLE,
        REG_STANCE_ONLY_MODE,
        REG_STANCE_DAMPING,
        REG_SWING_DAMPING,
        REG_BLEND_FACTOR,
        REG_TORQUE_LIMIT,
        REG_UNUSED
    } reg_idx_t;

endpackage

// ===== sv/sstc_mul.sv =====
module sstc_mul
    import sstc_pkg::*;
(
    input  logic                       aclk,
    input  logic signed [MUL_A_W-1:0]  a,
    input  logic signed [MUL_B_W-1:0]  b,
    output logic signed [MUL_P_W-1:0]  p
);

    logic signed [MUL_P_W-1:0] p_reg;

    // Registered signed multiply, shared by the blend, spring and damping steps of the sequencer.
    always_ff @(posedge aclk) begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== sv/stance_stiffness_torque_control_unit.sv =====
// Hip torque controller for two legs, one item per control tick.
// The input channel (s_valid/s_ready) carries a start flag, the right and left
// hip angles and the two foot-contact flags. The result channel
// (m_valid/m_ready) carries the saturated right and left torques and a clip
// flag for each. The APB port holds the seven gain, angle and limit registers;
// pready is always high and writes land in the access cycle.
// Each item is worked through by one shared signed multiplier under a step
// counter: two gain blend products, two spring products and two damping
// products, then a step that clamps both torques. s_ready returns together
// with the valid result, so the block takes no new item while one is still
// being worked through. A finished result sits in an output register, so
// the next item is accepted while the receiver stalls; only if that result
// is still not taken when the next one is ready does the sequencer hold in
// its last step.
// Reset loads the register defaults, clears both blended gains and previous
// angles, and leaves both channels empty.
module stance_stiffness_torque_control_unit
    import sstc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_start_req,
    input  logic signed [ANGLE_BITS-1:0] s_angle_right,
    input  logic signed [ANGLE_BITS-1:0] s_angle_left,
    input  logic                         s_contact_right,
    input  logic                         s_contact_left,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [TORQUE_W-1:0]   m_torque_right,
    output logic signed [TORQUE_W-1:0]   m_torque_left,
    output logic                         m_clipped_right,
    output logic                         m_clipped_left
);

    // Configuration registers.
    logic [STIFF_W-1:0]       stiffness_reg;
    logic signed [EQ_W-1:0]   eq_angle_reg;
    logic                     stance_only_reg;
    logic [DAMP_W-1:0]        stance_damp_reg;
    logic [DAMP_W-1:0]        swing_damp_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    reg_idx_t                 reg_idx;
    logic                     cfg_write;

    // Sequencer.
    state_t                   state_reg, state_next;
    step_t                    step_reg, step_next;

    // Per-leg state and working registers.
    logic [GAIN_W-1:0]               gain_r_reg, gain_l_reg;
    logic signed [ANGLE_BITS-1:0]    prev_r_reg, prev_l_reg;
    logic signed [ANGLE_BITS-1:0]    angle_r_reg, angle_l_reg;
    logic signed [DELTA_W-1:0]       delta_r_reg, delta_l_reg;
    logic                            contact_r_reg, contact_l_reg;
    logic signed [MUL_P_W-1:0]       acc_r_reg, acc_l_reg;

    // Output register.
    logic                            m_valid_reg;
    logic signed [TORQUE_W-1:0]      torque_r_reg, torque_l_reg;
    logic                            clip_r_reg, clip_l_reg;

    // Shared multiplier.
    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [MUL_B_W-1:0]       mul_b;
    logic signed [MUL_P_W-1:0]       prod;

    logic                            in_accept;
    logic                            out_load;
    logic                            active_r, active_l;
    logic [GAIN_W-1:0]               target_r, target_l;
    logic signed [ERR_W-1:0]         err_r, err_l;
    logic [GAIN_W-1:0]               gain_sel;
    logic signed [MUL_P_W-1:0]       blend_sum;
    logic [GAIN_W-1:0]               gain_new;
    logic signed [MUL_P_W-1:0]       spring_val;
    logic signed [MUL_P_W-1:0]       lim_pos, lim_neg;
    logic signed [MUL_P_W-1:0]       clamp_r, clamp_l;
    logic                            clip_r, clip_l;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg   <= STIFF_W'(1024);
            eq_angle_reg    <= '0;
            stance_only_reg <= 1'b1;
            stance_damp_reg <= DAMP_W'(150);
            swing_damp_reg  <= DAMP_W'(50);
            alpha_reg       <= ALPHA_W'(3277);
            limit_reg       <= LIMIT_W'(5000);
        end else if (cfg_write) begin
            case (reg_idx)
                REG_STANCE_STIFFNESS:  stiffness_reg   <= pwdata[STIFF_W-1:0];
                REG_EQUILIBRIUM_ANGLE: eq_angle_reg    <= signed'(pwdata[EQ_W-1:0]);
                REG_STANCE_ONLY_MODE:  stance_only_reg <= pwdata[0];
                REG_STANCE_DAMPING:    stance_damp_reg <= pwdata[DAMP_W-1:0];
                REG_SWING_DAMPING:     swing_damp_reg  <= pwdata[DAMP_W-1:0];
                REG_BLEND_FACTOR:      alpha_reg       <= pwdata[ALPHA_W-1:0];
                REG_TORQUE_LIMIT:      limit_reg       <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STANCE_STIFFNESS:  prdata = APB_DATA_W'(stiffness_reg);
            REG_EQUILIBRIUM_ANGLE: prdata = APB_DATA_W'(eq_angle_reg);
            REG_STANCE_ONLY_MODE:  prdata = APB_DATA_W'(stance_only_reg);
            REG_STANCE_DAMPING:    prdata = APB_DATA_W'(stance_damp_reg);
            REG_SWING_DAMPING:     prdata = APB_DATA_W'(swing_damp_reg);
            REG_BLEND_FACTOR:      prdata = APB_DATA_W'(alpha_reg);
            REG_TORQUE_LIMIT:      prdata = APB_DATA_W'(limit_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_BLEND_R;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_RUN;
                    step_next  = STEP_BLEND_R;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_OUT) begin
                    // Hold here while the previous result is still unclaimed.
                    if (!m_valid_reg || m_ready) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                        step_next  = STEP_BLEND_R;
                    end
                end else begin
                    step_next = step_t'(step_reg + 3'd1);
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = STEP_BLEND_R;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Multiplier operand selection
    // ------------------------------------------------------------------
    assign active_r = contact_r_reg || !stance_only_reg;
    assign active_l = contact_l_reg || !stance_only_reg;
    assign target_r = active_r ? (GAIN_W'(stiffness_reg) << BLEND_SHIFT) : '0;
    assign target_l = active_l ? (GAIN_W'(stiffness_reg) << BLEND_SHIFT) : '0;
    assign err_r    = ERR_W'(eq_angle_reg) - ERR_W'(angle_r_reg);
    assign err_l    = ERR_W'(eq_angle_reg) - ERR_W'(angle_l_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_BLEND_R: begin
                mul_a = signed'({1'b0, target_r}) - signed'({1'b0, gain_r_reg});
                mul_b = signed'(MUL_B_W'(alpha_reg));
            end
            STEP_BLEND_L: begin
                mul_a = signed'({1'b0, target_l}) - signed'({1'b0, gain_l_reg});
                mul_b = signed'(MUL_B_W'(alpha_reg));
            end
            STEP_SPRING_R: begin
                mul_a = signed'({1'b0, gain_r_reg});
                mul_b = MUL_B_W'(err_r);
            end
            STEP_SPRING_L: begin
                mul_a = signed'({1'b0, gain_l_reg});
                mul_b = MUL_B_W'(err_l);
            end
            STEP_DAMP_R: begin
                mul_a = MUL_A_W'(delta_r_reg);
                mul_b = signed'(MUL_B_W'(contact_r_reg ? stance_damp_reg : swing_damp_reg));
            end
            STEP_DAMP_L: begin
                mul_a = MUL_A_W'(delta_l_reg);
                mul_b = signed'(MUL_B_W'(contact_l_reg ? stance_damp_reg : swing_damp_reg));
            end
            default: begin
            end
        endcase
    end

    sstc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    // ------------------------------------------------------------------
    // Product retirement
    // ------------------------------------------------------------------
    // The blend step can only undershoot zero through rounding; it never
    // exceeds the target, so the gain stays within its width.
    assign gain_sel   = (step_reg == STEP_BLEND_L) ? gain_r_reg : gain_l_reg;
    assign blend_sum  = MUL_P_W'(signed'({1'b0, gain_sel})) + (prod >>> BLEND_SHIFT);
    assign gain_new   = blend_sum[MUL_P_W-1] ? '0 : blend_sum[GAIN_W-1:0];
    assign spring_val = prod >>> SPRING_SHIFT;

    assign lim_pos = signed'(MUL_P_W'(limit_reg));
    assign lim_neg = -lim_pos;

    always_comb begin
        clamp_r = acc_r_reg;
        clip_r  = 1'b0;
        if (acc_r_reg > lim_pos) begin
            clamp_r = lim_pos;
            clip_r  = 1'b1;
        end else if (acc_r_reg < lim_neg) begin
            clamp_r = lim_neg;
            clip_r  = 1'b1;
        end
        clamp_l = acc_l_reg;
        clip_l  = 1'b0;
        if (acc_l_reg > lim_pos) begin
            clamp_l = lim_pos;
            clip_l  = 1'b1;
        end else if (acc_l_reg < lim_neg) begin
            clamp_l = lim_neg;
            clip_l  = 1'b1;
        end
    end

    // Controller state: blended gains and previous angles. A start request
    // clears the gains and makes the angle change of this tick zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_r_reg <= '0;
            gain_l_reg <= '0;
            prev_r_reg <= '0;
            prev_l_reg <= '0;
        end else if (in_accept) begin
            prev_r_reg <= s_angle_right;
            prev_l_reg <= s_angle_left;
            if (s_start_req) begin
                gain_r_reg <= '0;
                gain_l_reg <= '0;
            end
        end else if (state_reg == ST_RUN) begin
            if (step_reg == STEP_BLEND_L) begin
                gain_r_reg <= gain_new;
            end
            if (step_reg == STEP_SPRING_R) begin
                gain_l_reg <= gain_new;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            angle_r_reg   <= s_angle_right;
            angle_l_reg   <= s_angle_left;
            contact_r_reg <= s_contact_right;
            contact_l_reg <= s_contact_left;
            delta_r_reg   <= s_start_req ? '0
                           : DELTA_W'(s_angle_right) - DELTA_W'(prev_r_reg);
            delta_l_reg   <= s_start_req ? '0
                           : DELTA_W'(s_angle_left) - DELTA_W'(prev_l_reg);
        end
        case (step_reg)
            STEP_SPRING_L: acc_r_reg <= contact_r_reg ? spring_val : '0;
            STEP_DAMP_R:   acc_l_reg <= contact_l_reg ? spring_val : '0;
            STEP_DAMP_L:   acc_r_reg <= acc_r_reg - prod;
            STEP_SUM_L:    acc_l_reg <= acc_l_reg - prod;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            torque_r_reg <= clamp_r[TORQUE_W-1:0];
            torque_l_reg <= clamp_l[TORQUE_W-1:0];
            clip_r_reg   <= clip_r;
            clip_l_reg   <= clip_l;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_torque_right  = torque_r_reg;
    assign m_torque_left   = torque_l_reg;
    assign m_clipped_right = clip_r_reg;
    assign m_clipped_left  = clip_l_reg;

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import sstc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // One control tick as it enters the block, and the torque command it causes.
    typedef struct packed {
        logic                  start_req;
        logic [ANGLE_BITS-1:0] angle_right;
        logic [ANGLE_BITS-1:0] angle_left;
        logic                  contact_right;
        logic                  contact_left;
    } tick_t;

    typedef struct packed {
        logic [TORQUE_W-1:0] torque_right;
        logic [TORQUE_W-1:0] torque_left;
        logic                clipped_right;
        logic                clipped_left;
    } torque_cmd_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_W-1:0]        paddr;
    logic [APB_DATA_W-1:0]        pwdata;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_start_req = 1'b0;
    logic signed [ANGLE_BITS-1:0] s_angle_right = '0;
    logic signed [ANGLE_BITS-1:0] s_angle_left = '0;
    logic                         s_contact_right = 1'b0;
    logic                         s_contact_left = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [TORQUE_W-1:0]   m_torque_right;
    logic signed [TORQUE_W-1:0]   m_torque_left;
    logic                         m_clipped_right;
    logic                         m_clipped_left;

    stance_stiffness_torque_control_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_angle_right   (s_angle_right),
        .s_angle_left    (s_angle_left),
        .s_contact_right (s_contact_right),
        .s_contact_left  (s_contact_left),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_torque_right  (m_torque_right),
        .m_torque_left   (m_torque_left),
        .m_clipped_right (m_clipped_right),
        .m_clipped_left  (m_clipped_left)
    );

    // Ticks waiting to be driven, and torque commands waiting to come out.
    tick_t       pending_ticks[$];
    torque_cmd_t torque_due[$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic        in_taken = 1'b0;

    // Register copies that the torque prediction works from.
    logic [STIFF_W-1:0]        cfg_stiffness;
    logic signed [EQ_W-1:0]    cfg_equilibrium;
    logic                      cfg_stance_only;
    logic [DAMP_W-1:0]         cfg_stance_damping;
    logic [DAMP_W-1:0]         cfg_swing_damping;
    logic [ALPHA_W-1:0]        cfg_blend;
    logic [LIMIT_W-1:0]        cfg_torque_limit;

    // Controller state as the predictor tracks it.
    logic [GAIN_W-1:0]            gain_right;
    logic [GAIN_W-1:0]            gain_left;
    logic signed [ANGLE_BITS-1:0] last_angle_right;
    logic signed [ANGLE_BITS-1:0] last_angle_left;

    // Walking pattern that the random ticks follow most of the time.
    int   walk_right;
    int   walk_left;
    logic stance_right;
    logic stance_left;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic reset_model();
        cfg_stiffness      = 12'd1024;
        cfg_equilibrium    = '0;
        cfg_stance_only    = 1'b1;
        cfg_stance_damping = 10'd150;
        cfg_swing_damping  = 10'd50;
        cfg_blend          = 16'd3277;
        cfg_torque_limit   = 15'd5000;
        gain_right         = '0;
        gain_left          = '0;
        last_angle_right   = '0;
        last_angle_left    = '0;
    endtask

    function automatic void apply_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_STANCE_STIFFNESS:  cfg_stiffness      = value[STIFF_W-1:0];
            REG_EQUILIBRIUM_ANGLE: cfg_equilibrium    = value[EQ_W-1:0];
            REG_STANCE_ONLY_MODE:  cfg_stance_only    = value[0];
            REG_STANCE_DAMPING:    cfg_stance_damping = value[DAMP_W-1:0];
            REG_SWING_DAMPING:     cfg_swing_damping  = value[DAMP_W-1:0];
            REG_BLEND_FACTOR:      cfg_blend          = value[ALPHA_W-1:0];
            REG_TORQUE_LIMIT:      cfg_torque_limit   = value[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // Low-pass step of a stored gain toward its target; the shift floors.
    function automatic logic [GAIN_W-1:0] blend_gain(input logic [GAIN_W-1:0] gain,
                                                     input logic active);
        longint goal;
        longint next_gain;
        goal = active ? (longint'(cfg_stiffness) <<< BLEND_SHIFT) : 64'sd0;
        next_gain = longint'(gain)
                  + (((goal - longint'(gain)) * longint'(cfg_blend)) >>> BLEND_SHIFT);
        if (next_gain < 0)
            next_gain = 0;
        return next_gain[GAIN_W-1:0];
    endfunction

    // Spring plus stance damping in contact, swing damping otherwise, then the clamp.
    function automatic void leg_torque(input logic signed [ANGLE_BITS-1:0] angle,
                                       input logic signed [ANGLE_BITS-1:0] prev,
                                       input logic contact,
                                       input logic [GAIN_W-1:0] gain,
                                       output logic [TORQUE_W-1:0] torque,
                                       output logic clip);
        longint delta;
        longint raw;
        longint lim;
        delta = longint'(angle) - longint'(prev);
        lim = longint'(cfg_torque_limit);
        if (contact)
            raw = ((longint'(gain) * (longint'(cfg_equilibrium) - longint'(angle)))
                   >>> SPRING_SHIFT) - longint'(cfg_stance_damping) * delta;
        else
            raw = -(longint'(cfg_swing_damping) * delta);
        clip = 1'b0;
        if (raw > lim) begin
            raw = lim;
            clip = 1'b1;
        end
        if (raw < -lim) begin
            raw = -lim;
            clip = 1'b1;
        end
        torque = raw[TORQUE_W-1:0];
    endfunction

    function automatic torque_cmd_t predict_torques(input tick_t t);
        torque_cmd_t                  cmd;
        logic signed [ANGLE_BITS-1:0] ar;
        logic signed [ANGLE_BITS-1:0] al;
        logic                         always_on;
        ar = t.angle_right;
        al = t.angle_left;
        always_on = !cfg_stance_only;
        // A start request clears both gains and seeds the angle history.
        if (t.start_req) begin
            gain_right = '0;
            gain_left = '0;
            last_angle_right = ar;
            last_angle_left = al;
        end
        gain_right = blend_gain(gain_right, t.contact_right || always_on);
        gain_left = blend_gain(gain_left, t.contact_left || always_on);
        leg_torque(ar, last_angle_right, t.contact_right, gain_right,
                   cmd.torque_right, cmd.clipped_right);
        leg_torque(al, last_angle_left, t.contact_left, gain_left,
                   cmd.torque_left, cmd.clipped_left);
        last_angle_right = ar;
        last_angle_left = al;
        return cmd;
    endfunction

    task automatic compare_field(input string label, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            error_count++;
        end
    endtask

    // Register write: a setup phase, then an access phase held until pready.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic load_regs(input logic [APB_DATA_W-1:0] stiffness, input int equilibrium,
                             input logic [APB_DATA_W-1:0] stance_only,
                             input logic [APB_DATA_W-1:0] stance_damp,
                             input logic [APB_DATA_W-1:0] swing_damp,
                             input logic [APB_DATA_W-1:0] blend,
                             input logic [APB_DATA_W-1:0] limit);
        write_reg(REG_STANCE_STIFFNESS, stiffness);
        write_reg(REG_EQUILIBRIUM_ANGLE, APB_DATA_W'(equilibrium));
        write_reg(REG_STANCE_ONLY_MODE, stance_only);
        write_reg(REG_STANCE_DAMPING, stance_damp);
        write_reg(REG_SWING_DAMPING, swing_damp);
        write_reg(REG_BLEND_FACTOR, blend);
        write_reg(REG_TORQUE_LIMIT, limit);
    endtask

    task automatic add_tick(input logic start, input int ar, input int al,
                            input logic cr, input logic cl);
        tick_t t;
        t.start_req     = start;
        t.angle_right   = ANGLE_BITS'(ar);
        t.angle_left    = ANGLE_BITS'(al);
        t.contact_right = cr;
        t.contact_left  = cl;
        pending_ticks.push_back(t);
    endtask

    // Mostly a walking pattern: small angle steps and alternating stance, with
    // occasional restarts. The rest is noise over the full angle field.
    task automatic queue_gait_ticks(input int count);
        int    pick;
        tick_t t;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                t.start_req     = ($urandom_range(9) == 0);
                t.angle_right   = ANGLE_BITS'($urandom);
                t.angle_left    = ANGLE_BITS'($urandom);
                t.contact_right = 1'($urandom_range(1));
                t.contact_left  = 1'($urandom_range(1));
            end else begin
                walk_right += int'($urandom_range(600)) - 300;
                walk_left  += int'($urandom_range(600)) - 300;
                if (walk_right > 18000) walk_right = 18000;
                if (walk_right < -18000) walk_right = -18000;
                if (walk_left > 18000) walk_left = 18000;
                if (walk_left < -18000) walk_left = -18000;
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(2))
                        0: {stance_right, stance_left} = 2'b10;
                        1: {stance_right, stance_left} = 2'b01;
                        default: {stance_right, stance_left} = 2'b11;
                    endcase
                end
                t.start_req     = (pick < 16);
                t.angle_right   = ANGLE_BITS'(walk_right);
                t.angle_left    = ANGLE_BITS'(walk_left);
                t.contact_right = stance_right;
                t.contact_left  = stance_left;
            end
            pending_ticks.push_back(t);
        end
    endtask

    // Waits until every tick is driven and every torque command has come out,
    // then lets the block's latency pass so that it is idle for a register write.
    task automatic wait_all_done();
        while (pending_ticks.size() > 0 || s_valid || torque_due.size() > 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // Sender: a new item goes out only once the previous one is taken, and the
    // payload stays put while valid is high.
    always @(negedge aclk) begin : sender
        tick_t next_tick;
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                next_tick = pending_ticks.pop_front();
                s_valid         <= 1'b1;
                s_start_req     <= next_tick.start_req;
                s_angle_right   <= next_tick.angle_right;
                s_angle_left    <= next_tick.angle_left;
                s_contact_right <= next_tick.contact_right;
                s_contact_left  <= next_tick.contact_left;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Predicts on every accepted item and checks every accepted torque command.
    always @(posedge aclk) begin : observer
        tick_t       seen;
        torque_cmd_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                seen.start_req     = s_start_req;
                seen.angle_right   = s_angle_right;
                seen.angle_left    = s_angle_left;
                seen.contact_right = s_contact_right;
                seen.contact_left  = s_contact_left;
                torque_due.push_back(predict_torques(seen));
            end
            if (m_valid && m_ready) begin
                if (torque_due.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %0d %0d %0b %0b",
                             $time, m_torque_right, m_torque_left,
                             m_clipped_right, m_clipped_left);
                    error_count++;
                end else begin
                    want = torque_due.pop_front();
                    compare_field("torque_right", longint'($signed(want.torque_right)),
                                  longint'(m_torque_right));
                    compare_field("torque_left", longint'($signed(want.torque_left)),
                                  longint'(m_torque_left));
                    compare_field("clipped_right", longint'(want.clipped_right),
                                  longint'(m_clipped_right));
                    compare_field("clipped_left", longint'(want.clipped_left),
                                  longint'(m_clipped_left));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d items still expected", $time, torque_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        walk_right = 0;
        walk_left = 0;
        stance_right = 1'b1;
        stance_left = 1'b0;
        reset_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks on the reset settings: a start, angle extremes in and
        // beyond the normal range, every contact pair, and a gain build-up.
        add_tick(1'b1, 0, 0, 1'b1, 1'b1);
        add_tick(1'b0, 1000, -1000, 1'b1, 1'b1);
        add_tick(1'b0, 18000, -18000, 1'b1, 1'b0);
        add_tick(1'b0, -18000, 18000, 1'b0, 1'b1);
        add_tick(1'b0, 32767, -32768, 1'b1, 1'b1);
        add_tick(1'b0, -32768, 32767, 1'b0, 1'b0);
        add_tick(1'b0, 0, 0, 1'b0, 1'b0);
        add_tick(1'b1, 500, -500, 1'b0, 1'b0);
        add_tick(1'b0, 'h5555, 'hAAAA, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++)
            add_tick(1'b0, 200 * i, -300 * i, 1'b1, 1'b1);
        wait_all_done();

        // A torque limit of zero with the largest gain and blend, gain always on,
        // and a write to the unused register index that must change nothing.
        load_regs(32'd4095, -1024, 32'd0, 32'd1023, 32'd1023, 32'd65535, 32'd0);
        write_reg(REG_UNUSED, $urandom);
        add_tick(1'b1, 100, -100, 1'b1, 1'b0);
        add_tick(1'b0, 0, 0, 1'b1, 1'b1);
        add_tick(1'b0, 0, 0, 1'b0, 1'b0);
        add_tick(1'b0, 18000, -18000, 1'b0, 1'b1);
        add_tick(1'b0, -1024, -1024, 1'b1, 1'b1);
        add_tick(1'b0, -32768, 32767, 1'b1, 1'b1);
        add_tick(1'b0, -32768, 32767, 1'b0, 1'b0);
        wait_all_done();

        // Random phases, each with its own settings and flow-control pattern.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    load_regs($urandom_range(4095), int'($urandom), $urandom_range(1),
                              $urandom_range(1023), $urandom_range(1023), $urandom,
                              $urandom_range(32767));
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    load_regs($urandom, int'($urandom_range(2000)) - 1000, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
                    src_idle_pct = 66;
                    sink_stall_pct = 0;
                end
                2: begin
                    load_regs(32'd1024, int'($urandom_range(2000)) - 1000, 32'd1,
                              32'd150, 32'd50, 32'd3277, 32'd5000);
                    src_idle_pct = 0;
                    sink_stall_pct = 66;
                end
                3: begin
                    load_regs($urandom_range(4095), int'($urandom), $urandom_range(1),
                              $urandom_range(1023), $urandom_range(1023), $urandom,
                              $urandom_range(32767));
                    src_idle_pct = 30;
                    sink_stall_pct = 30;
                end
                4: begin
                    load_regs(32'd4095, 1023, 32'd1, 32'd1023, 32'd1023, 32'd65535,
                              32'd32767);
                    src_idle_pct = 30;
                    sink_stall_pct = 0;
                end
                default: begin
                    load_regs(32'd0, -1024, 32'd0, 32'd0, 32'd0, 32'd0, 32'd32767);
                    src_idle_pct = 0;
                    sink_stall_pct = 30;
                end
            endcase
            if (phase == 1) begin
                // The sender holds off halfway until the block has drained.
                queue_gait_ticks(120);
                wait_all_done();
                queue_gait_ticks(120);
            end else begin
                queue_gait_ticks(240);
            end
            wait_all_done();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
